[sv/wrrl_pkg.sv]
// ----------------------------------------------------------------------------
// wrrl_pkg: shared types and constants for the weighted round-robin run list
// Slot pool size, field widths, operation and status codes, and the command
// and status bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package wrrl_pkg;

   // Pool and priority sizing
   localparam int TASK_SLOTS    = 16;
   localparam int PRIORITY_BITS = 4;
   localparam int SLOT_W        = $clog2(TASK_SLOTS);
   localparam int CNT_W         = $clog2(TASK_SLOTS + 1);

   // Item field widths
   localparam int OP_W       = 2;
   localparam int ID_W       = 4;
   localparam int PRIO_IN_W  = 4;
   localparam int DEADLINE_W = 64;
   localparam int COUNT_W    = 5;
   localparam int STATUS_W   = 2;

   // Configuration registers
   localparam int TICKS_W     = 16;
   localparam int START_W     = 32;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 32;
   localparam int TICKS_RESET = 10;
   localparam int START_DEADLINE_RESET = 0;

   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_UNIT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_START_DEADLINE = CSR_IDX_W'(1);

   // Slice product: priority times ticks per unit
   localparam int PROD_W = PRIORITY_BITS + TICKS_W;

   // Stream packing
   localparam int REQ_DATA_W    = ((ID_W + PRIO_IN_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W  = 1 + ID_W + DEADLINE_W + COUNT_W;
   localparam int RSP_DATA_W    = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_COUNT_LSB = 1 + ID_W + DEADLINE_W;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC = 2'd0,
      OP_WAKE  = 2'd1,
      OP_TICK  = 2'd2,
      OP_SLEEP = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE       = 2'd0,
      ST_NO_EFFECT  = 2'd1,
      ST_NO_SLOT    = 2'd2,
      ST_LIST_EMPTY = 2'd3
   } stat_type;

   typedef enum logic [1:0] {
      SLOT_FREE    = 2'd0,
      SLOT_USED    = 2'd1,
      SLOT_RUNNING = 2'd2
   } slot_state_type;

   // One datapath command per controller step
   typedef enum logic [4:0] {
      CMD_NOP,
      CMD_LOAD,
      CMD_ALLOC,
      CMD_REG_CHECK,
      CMD_REG_READ,
      CMD_REG_CMP,
      CMD_SCH_ADV,
      CMD_SCH_READ,
      CMD_SCH_MUL,
      CMD_SCH_ADD,
      CMD_SLP_CHECK,
      CMD_SLP_CUR,
      CMD_SLP_FIND,
      CMD_SLP_SHIFT,
      CMD_SLP_FIN,
      CMD_SLP_TGT,
      CMD_OUT
   } cmd_type;

   // Datapath flags seen by the controller
   typedef struct packed {
      logic slot_free;   // addressed slot is free
      logic scan_last;   // allocate scan at the last slot
      logic reg_skip;    // wake has no list effect
      logic slp_skip;    // sleep has no effect
      logic list_empty;  // run list holds no task
      logic pos_end;     // list walk position at or past the count
      logic find_hit;    // list entry read matches the item's slot
      logic was_current; // sleeper was the current task
      logic out_free;    // result register can take a new item
   } dp_stat_type;

endpackage

`default_nettype wire

[sv/wrrl_ctrl.sv]
// ----------------------------------------------------------------------------
// wrrl_ctrl: sequencing controller
// Decodes the operation of an accepted item and steps the datapath through
// the allocate scan, wake, schedule or sleep sequence, then hands the result
// to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wrrl_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  wrrl_pkg::op_type     req_op,
   input  wrrl_pkg::dp_stat_type dp_stat,
   output wrrl_pkg::cmd_type    dp_cmd
);
   import wrrl_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ALLOC,
      S_REG_CHECK,
      S_REG_READ,
      S_REG_CMP,
      S_SCH_ADV,
      S_SCH_READ,
      S_SCH_MUL,
      S_SCH_ADD,
      S_SLP_CHECK,
      S_SLP_CUR,
      S_SLP_FIND,
      S_SLP_SHIFT,
      S_SLP_FIN,
      S_SLP_TGT,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               case (req_op)
                  OP_ALLOC: state_in = S_ALLOC;
                  OP_WAKE:  state_in = S_REG_CHECK;
                  OP_TICK:  state_in = S_SCH_ADV;
                  OP_SLEEP: state_in = S_SLP_CHECK;
                  default:  state_in = S_IDLE;
               endcase
            end
         end
         S_ALLOC: begin
            if (dp_stat.slot_free || dp_stat.scan_last) state_in = S_DONE;
         end
         S_REG_CHECK: state_in = dp_stat.reg_skip ? S_DONE : S_REG_READ;
         S_REG_READ:  state_in = S_REG_CMP;
         S_REG_CMP:   state_in = S_DONE;
         S_SCH_ADV:   state_in = dp_stat.list_empty ? S_DONE : S_SCH_READ;
         S_SCH_READ:  state_in = S_SCH_MUL;
         S_SCH_MUL:   state_in = S_SCH_ADD;
         S_SCH_ADD:   state_in = S_DONE;
         S_SLP_CHECK: state_in = dp_stat.slp_skip ? S_DONE : S_SLP_CUR;
         S_SLP_CUR:   state_in = S_SLP_FIND;
         S_SLP_FIND: begin
            if (dp_stat.pos_end)       state_in = S_SLP_FIN;
            else if (dp_stat.find_hit) state_in = S_SLP_SHIFT;
         end
         S_SLP_SHIFT: begin
            if (dp_stat.pos_end) state_in = S_SLP_FIN;
         end
         S_SLP_FIN: begin
            if (dp_stat.was_current && !dp_stat.list_empty) state_in = S_SLP_TGT;
            else                                            state_in = S_DONE;
         end
         S_SLP_TGT: state_in = S_DONE;
         S_DONE: begin
            if (dp_stat.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Command decode
   always_comb begin
      case (state_ff)
         S_IDLE:      dp_cmd = req_tvalid ? CMD_LOAD : CMD_NOP;
         S_ALLOC:     dp_cmd = CMD_ALLOC;
         S_REG_CHECK: dp_cmd = CMD_REG_CHECK;
         S_REG_READ:  dp_cmd = CMD_REG_READ;
         S_REG_CMP:   dp_cmd = CMD_REG_CMP;
         S_SCH_ADV:   dp_cmd = CMD_SCH_ADV;
         S_SCH_READ:  dp_cmd = CMD_SCH_READ;
         S_SCH_MUL:   dp_cmd = CMD_SCH_MUL;
         S_SCH_ADD:   dp_cmd = CMD_SCH_ADD;
         S_SLP_CHECK: dp_cmd = CMD_SLP_CHECK;
         S_SLP_CUR:   dp_cmd = CMD_SLP_CUR;
         S_SLP_FIND:  dp_cmd = CMD_SLP_FIND;
         S_SLP_SHIFT: dp_cmd = CMD_SLP_SHIFT;
         S_SLP_FIN:   dp_cmd = CMD_SLP_FIN;
         S_SLP_TGT:   dp_cmd = CMD_SLP_TGT;
         S_DONE:      dp_cmd = dp_stat.out_free ? CMD_OUT : CMD_NOP;
         default:     dp_cmd = CMD_NOP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[sv/wrrl_dp.sv]
// ----------------------------------------------------------------------------
// wrrl_dp: scheduler datapath
// Slot state and priority tables, run list memory with a registered read
// port, list count and current position, deadline with its slice multiplier,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wrrl_dp (
   input  wire                              clock,
   input  wire                              reset,
   input  wrrl_pkg::cmd_type                dp_cmd,
   output wrrl_pkg::dp_stat_type            dp_stat,
   input  wire [wrrl_pkg::ID_W-1:0]         req_task_id,
   input  wire [wrrl_pkg::PRIO_IN_W-1:0]    req_priority,
   input  wire                              csr_we,
   input  wire [wrrl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire [wrrl_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [wrrl_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [wrrl_pkg::STATUS_W-1:0]    rsp_tuser
);
   import wrrl_pkg::*;

   // Slot tables and list bookkeeping
   slot_state_type           slot_state_ff [TASK_SLOTS];
   logic [PRIORITY_BITS-1:0] slot_prio_ff  [TASK_SLOTS];
   logic [CNT_W-1:0]         cnt_ff;
   logic [SLOT_W-1:0]        cur_ff;
   logic [DEADLINE_W-1:0]    deadline_ff;
   logic [TICKS_W-1:0]       ticks_ff;
   logic                     rsp_valid_ff;

   // Run list memory
   logic [SLOT_W-1:0]        run_mem [TASK_SLOTS];
   logic [SLOT_W-1:0]        rd_ff;

   // Per-item working registers
   logic [ID_W-1:0]          id_ff;
   logic [PRIORITY_BITS-1:0] prio_ff;
   logic [SLOT_W-1:0]        scan_ff;
   logic [CNT_W-1:0]         pos_ff;
   logic [ID_W-1:0]          tgt_ff;
   logic                     sw_ff;
   stat_type                 stat_ff;
   logic                     was_ff;
   logic [PROD_W-1:0]        prod_ff;
   logic [RSP_DATA_W-1:0]    rsp_data_ff;
   stat_type                 rsp_user_ff;

   logic [SLOT_W-1:0]        id_slot;
   logic                     id_bad;
   logic [SLOT_W-1:0]        slot_addr;
   slot_state_type           slot_rd_state;
   logic [PRIORITY_BITS-1:0] slot_rd_prio;
   logic [CNT_W-1:0]         cur_ext;
   logic [CNT_W-1:0]         cnt_inc;
   logic [SLOT_W-1:0]        cur_step;
   logic [SLOT_W-1:0]        cur_fix;
   logic [CNT_W-1:0]         pos_p1;
   logic [CNT_W-1:0]         pos_p2;
   logic [SLOT_W-1:0]        rd_addr;
   logic                     wr_en;
   logic [SLOT_W-1:0]        wr_addr;
   logic [SLOT_W-1:0]        wr_data;
   logic [PROD_W-1:0]        prod_in;
   logic                     out_free;

   assign id_slot = SLOT_W'(id_ff);
   assign id_bad  = ({1'b0, id_ff} >= (ID_W + 1)'(TASK_SLOTS));
   assign cur_ext = CNT_W'(cur_ff);
   assign cnt_inc = cnt_ff + 1'b1;
   assign pos_p1  = pos_ff + 1'b1;
   assign pos_p2  = pos_ff + CNT_W'(2);

   // Round-robin advance and position repair after the list shrinks
   assign cur_step = ((cur_ext + 1'b1) >= cnt_ff) ? '0 : cur_ff + 1'b1;
   assign cur_fix  = (cur_ext >= cnt_ff) ? '0 : cur_ff;

   // One address into the slot tables
   always_comb begin
      case (dp_cmd)
         CMD_ALLOC:               slot_addr = scan_ff;
         CMD_REG_CMP, CMD_SCH_MUL: slot_addr = rd_ff;
         default:                 slot_addr = id_slot;
      endcase
   end

   assign slot_rd_state = slot_state_ff[slot_addr];
   assign slot_rd_prio  = slot_prio_ff[slot_addr];
   assign prod_in       = PROD_W'(slot_rd_prio) * PROD_W'(ticks_ff);

   // Run list read address: current task, or the list walk ahead of writes
   always_comb begin
      case (dp_cmd)
         CMD_SLP_CUR:   rd_addr = pos_ff[SLOT_W-1:0];
         CMD_SLP_FIND:  rd_addr = pos_p1[SLOT_W-1:0];
         CMD_SLP_SHIFT: rd_addr = pos_p2[SLOT_W-1:0];
         CMD_SLP_FIN:   rd_addr = cur_fix;
         default:       rd_addr = cur_ff;
      endcase
   end

   // Status flags
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      dp_stat.slot_free   = (slot_rd_state == SLOT_FREE);
      dp_stat.scan_last   = (scan_ff == SLOT_W'(TASK_SLOTS - 1));
      dp_stat.reg_skip    = id_bad || (slot_rd_state == SLOT_RUNNING);
      dp_stat.slp_skip    = id_bad || (slot_rd_state != SLOT_RUNNING) || (cnt_ff == '0);
      dp_stat.list_empty  = (cnt_ff == '0);
      dp_stat.pos_end     = (pos_ff >= cnt_ff);
      dp_stat.find_hit    = (rd_ff == id_slot);
      dp_stat.was_current = was_ff;
      dp_stat.out_free    = out_free;
   end

   // Run list writes: append on wake, move down one place on sleep
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cnt_ff[SLOT_W-1:0];
      wr_data = id_slot;
      case (dp_cmd)
         CMD_REG_CHECK: begin
            wr_en = !dp_stat.reg_skip;
         end
         CMD_SLP_SHIFT: begin
            wr_en   = !dp_stat.pos_end;
            wr_addr = pos_ff[SLOT_W-1:0];
            wr_data = rd_ff;
         end
         default: wr_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         run_mem[wr_addr] <= wr_data;
      end
      rd_ff <= run_mem[rd_addr];
   end

   // Control state: slot tables, list count and position, deadline, config
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TASK_SLOTS; i++) begin
            slot_state_ff[i] <= SLOT_FREE;
            slot_prio_ff[i]  <= '0;
         end
         cnt_ff       <= '0;
         cur_ff       <= '0;
         deadline_ff  <= DEADLINE_W'(START_DEADLINE_RESET);
         ticks_ff     <= TICKS_W'(TICKS_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_TICKS_PER_UNIT: ticks_ff <= csr_wdata[TICKS_W-1:0];
               CSR_START_DEADLINE: deadline_ff <= DEADLINE_W'(csr_wdata[START_W-1:0]);
               default: ;
            endcase
         end

         case (dp_cmd)
            CMD_ALLOC: begin
               if (dp_stat.slot_free) slot_state_ff[slot_addr] <= SLOT_USED;
            end
            CMD_REG_CHECK: begin
               if (!id_bad) slot_prio_ff[slot_addr] <= prio_ff;
               if (!dp_stat.reg_skip) begin
                  slot_state_ff[slot_addr] <= SLOT_RUNNING;
                  cnt_ff <= cnt_inc;
                  if (cur_ext >= cnt_inc) cur_ff <= '0;
               end
            end
            CMD_REG_CMP: begin
               // preempt to the newcomer
               if (prio_ff > slot_rd_prio) cur_ff <= SLOT_W'(cnt_ff - 1'b1);
            end
            CMD_SCH_ADV: begin
               if (!dp_stat.list_empty) cur_ff <= cur_step;
            end
            CMD_SCH_ADD: begin
               if (!(csr_we && csr_index == CSR_START_DEADLINE)) begin
                  deadline_ff <= deadline_ff + DEADLINE_W'(prod_ff);
               end
            end
            CMD_SLP_FIND: begin
               if (!dp_stat.pos_end && dp_stat.find_hit) begin
                  cnt_ff <= cnt_ff - 1'b1;
                  if (pos_ff < cur_ext) cur_ff <= cur_ff - 1'b1;
               end
            end
            CMD_SLP_FIN: begin
               slot_state_ff[slot_addr] <= SLOT_USED;
               cur_ff <= cur_fix;
            end
            default: ;
         endcase

         // Result register
         if (dp_cmd == CMD_OUT)  rsp_valid_ff <= 1'b1;
         else if (rsp_tready)    rsp_valid_ff <= 1'b0;
      end
   end

   // Per-item working registers and result payload
   always_ff @(posedge clock) begin
      case (dp_cmd)
         CMD_LOAD: begin
            id_ff   <= req_task_id;
            prio_ff <= PRIORITY_BITS'(req_priority);
            scan_ff <= '0;
            pos_ff  <= '0;
            tgt_ff  <= req_task_id;
            sw_ff   <= 1'b0;
            stat_ff <= ST_DONE;
            was_ff  <= 1'b0;
         end
         CMD_ALLOC: begin
            if (dp_stat.slot_free) begin
               tgt_ff <= ID_W'(scan_ff);
            end else if (dp_stat.scan_last) begin
               tgt_ff  <= '0;
               stat_ff <= ST_NO_SLOT;
            end else begin
               scan_ff <= scan_ff + 1'b1;
            end
         end
         CMD_REG_CHECK: begin
            if (dp_stat.reg_skip) stat_ff <= ST_NO_EFFECT;
         end
         CMD_REG_CMP: begin
            if (prio_ff > slot_rd_prio) sw_ff <= 1'b1;
         end
         CMD_SCH_ADV: begin
            if (dp_stat.list_empty) begin
               tgt_ff  <= '0;
               stat_ff <= ST_LIST_EMPTY;
            end
         end
         CMD_SCH_MUL: begin
            prod_ff <= prod_in;
            tgt_ff  <= ID_W'(rd_ff);
            sw_ff   <= (cnt_ff >= CNT_W'(2));
         end
         CMD_SLP_CHECK: begin
            if (dp_stat.slp_skip) stat_ff <= ST_NO_EFFECT;
         end
         CMD_SLP_CUR: begin
            was_ff <= (cur_ext < cnt_ff) && (rd_ff == id_slot);
         end
         CMD_SLP_FIND: begin
            if (!dp_stat.pos_end && !dp_stat.find_hit) pos_ff <= pos_p1;
         end
         CMD_SLP_SHIFT: begin
            if (!dp_stat.pos_end) pos_ff <= pos_p1;
         end
         CMD_SLP_FIN: begin
            if (was_ff && dp_stat.list_empty) stat_ff <= ST_LIST_EMPTY;
         end
         CMD_SLP_TGT: begin
            tgt_ff <= ID_W'(rd_ff);
            sw_ff  <= 1'b1;
         end
         CMD_OUT: begin
            rsp_data_ff <= RSP_DATA_W'({COUNT_W'(cnt_ff), deadline_ff, tgt_ff, sw_ff});
            rsp_user_ff <= stat_ff;
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

[sv/weighted_round_robin_run_list.sv]
// ----------------------------------------------------------------------------
// weighted_round_robin_run_list: task slot pool with a weighted run list
// Allocates task slots, wakes tasks onto a round-robin run list with
// priority preemption, advances the schedule and its deadline, and puts
// tasks to sleep. One result item per request item.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request item (operation in tuser); rsp_* returns one
//   result item per request, in order. csr_* writes ticks_per_unit
//   (index 0) or start_deadline (index 1, also loads the deadline at once);
//   write only while no request is in flight.
//   Sequences after acceptance: allocate scans one slot per cycle for a
//   free slot; wake stops at once on a running task, else appends, reads
//   the current entry and compares priorities; schedule tick stops at once
//   on an empty list, else list read, then multiply, then 64-bit add; sleep
//   stops at once when it has no effect, else one list entry per cycle in
//   the search and the shift down, through the single run list read port.
//   One item is worked on at a time; req_tready rises again together with
//   rsp_tvalid, as the result enters the output register.
//   A stalled receiver holds the result in the output register; the next
//   item is still accepted and waits at the end of its sequence.
//   Reset (synchronous) frees all slots, clears priorities and the run list
//   count, sets ticks_per_unit to 10 and the deadline to 0. The run list
//   memory needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_round_robin_run_list (
   input  wire                               clock,
   input  wire                               reset,
   // request: tdata = task_id[3:0], priority_req[7:4]; tuser = op[1:0]
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire [wrrl_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire [wrrl_pkg::OP_W-1:0]          req_tuser,
   // result: tdata = switch_now[0], target_task[4:1], next_deadline[68:5],
   //         running_count[73:69], zero fill; tuser = status[1:0]
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [wrrl_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [wrrl_pkg::STATUS_W-1:0]     rsp_tuser,
   // configuration
   input  wire                               csr_we,
   input  wire [wrrl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire [wrrl_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import wrrl_pkg::*;

   cmd_type     dp_cmd;
   dp_stat_type dp_stat;
   op_type      req_op;

   assign req_op = op_type'(req_tuser);

   wrrl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_op),
      .dp_stat    (dp_stat),
      .dp_cmd     (dp_cmd)
   );

   wrrl_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .dp_cmd       (dp_cmd),
      .dp_stat      (dp_stat),
      .req_task_id  (req_tdata[ID_W-1:0]),
      .req_priority (req_tdata[ID_W+PRIO_IN_W-1:ID_W]),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser)
   );

`ifndef SYNTHESIS
   // An empty-list result always reports an empty run list
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ST_LIST_EMPTY)
         |-> (rsp_tdata[RSP_COUNT_LSB+COUNT_W-1:RSP_COUNT_LSB] == '0))
      else $error("list-empty result with tasks still on the run list");

   // A switch request only comes with a completed operation
   a_switch_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |-> (rsp_tuser == ST_DONE))
      else $error("switch requested on a failed or void operation");

   // The run list never holds more tasks than there are slots
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid
         |-> (rsp_tdata[RSP_COUNT_LSB+COUNT_W-1:RSP_COUNT_LSB] <= COUNT_W'(TASK_SLOTS)))
      else $error("running count beyond the slot pool");

   // Every accepted item keeps the block busy in the cycle after its acceptance
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while the previous item is in work");
`endif

endmodule

`default_nettype wire
